// ===== hw/rtl/dpfm_pkg.sv =====
// Shared types, widths and constants of the dominant-plane flow mask.
package dpfm_pkg;

  // Pixel coordinate width; only the low CoordBits bits of a coordinate are used.
  localparam int CoordBits = 12;

  localparam int FlowW   = 16;
  localparam int MatW    = 16;
  localparam int DiagW   = MatW + 1;
  localparam int OffW    = 24;
  localparam int TolW    = 16;
  localparam int TolSqW  = 2 * TolW;
  localparam int MaskW   = 8;
  localparam int CfgIdxW = 3;
  localparam int CfgW    = 24;

  // Product, sum, rounded and offset-added widths of the plane prediction.
  localparam int ProdW   = DiagW + CoordBits + 1;
  localparam int SumW    = ProdW + 2;
  localparam int FracW   = 8;
  localparam int ShW     = SumW - FracW;
  localparam int PlaneW  = ((ShW > OffW) ? ShW : OffW) + 1;

  // Flow difference and squared distance widths.
  localparam int DiffW   = FlowW + 1;
  localparam int SqW     = 2 * DiffW;
  localparam int DistW   = SqW + 1;

  localparam int Q14One    = 16384;
  localparam int RoundBias = 128;
  localparam int FlowMax   = 32767;
  localparam int FlowMin   = -32768;
  localparam int TolReset  = 64;

  localparam logic [MaskW-1:0] MaskOn  = 8'd255;
  localparam logic [MaskW-1:0] MaskOff = 8'd0;

  typedef enum logic [CfgIdxW-1:0] {
    CfgA11    = 3'd0,
    CfgA12    = 3'd1,
    CfgA21    = 3'd2,
    CfgA22    = 3'd3,
    CfgOffX   = 3'd4,
    CfgOffY   = 3'd5,
    CfgTol    = 3'd6
  } cfg_idx_e;

  // Clamp a predicted flow component to the signed 16-bit range.
  function automatic logic signed [FlowW-1:0] sat_flow(input logic signed [PlaneW-1:0] v);
    logic signed [FlowW-1:0] r;
    if (v > PlaneW'(FlowMax)) begin
      r = FlowW'(FlowMax);
    end else if (v < PlaneW'(FlowMin)) begin
      r = FlowW'(FlowMin);
    end else begin
      r = v[FlowW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/dpfm_if.sv =====
// Valid/ready channel interfaces for pixel transactions and result transactions.
interface dpfm_pix_if;
  import dpfm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CoordBits-1:0]    pixel_col;
  logic [CoordBits-1:0]    pixel_row;
  logic signed [FlowW-1:0] flow_x;
  logic signed [FlowW-1:0] flow_y;

  modport source (output valid, output pixel_col, output pixel_row, output flow_x,
                  output flow_y, input ready);
  modport sink   (input valid, input pixel_col, input pixel_row, input flow_x,
                  input flow_y, output ready);
endinterface

interface dpfm_res_if;
  import dpfm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [FlowW-1:0] plane_flow_x;
  logic signed [FlowW-1:0] plane_flow_y;
  logic [MaskW-1:0]        mask_value;

  modport source (output valid, output plane_flow_x, output plane_flow_y,
                  output mask_value, input ready);
  modport sink   (input valid, input plane_flow_x, input plane_flow_y,
                  input mask_value, output ready);
endinterface

// ===== hw/rtl/dominant_plane_flow_mask.sv =====
// Top level of the dominant-plane flow mask: a four-stage pixel pipeline.
// Throughput is one pixel per cycle; each stage holds when the stage after it is full and stalled.
// The pipeline stages are multiply, round and saturate, square, then compare and output.
// Reset (rst_ni low, asynchronous) empties the pipeline and returns every configuration
// register to its reset value: identity matrix, zero offsets, tolerance of 64.
module dominant_plane_flow_mask (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [dpfm_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [dpfm_pkg::CfgW-1:0]         cfg_data_i,
  dpfm_pix_if.sink                          pix_i,
  dpfm_res_if.source                        res_o
);
  import dpfm_pkg::*;

  // Configuration. The matrix diagonal is stored already reduced by one (A - I),
  // and the tolerance is stored squared, so neither costs logic in the pixel path.
  logic signed [DiagW-1:0]  diag_x_q, diag_y_q;
  logic signed [MatW-1:0]   cross_x_q, cross_y_q;
  logic signed [OffW-1:0]   off_x_q, off_y_q;
  logic [TolSqW-1:0]        tol_sq_q;
  logic [TolW-1:0]          tol_wr;

  assign tol_wr = cfg_data_i[TolW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diag_x_q  <= '0;
      diag_y_q  <= '0;
      cross_x_q <= '0;
      cross_y_q <= '0;
      off_x_q   <= '0;
      off_y_q   <= '0;
      tol_sq_q  <= TolSqW'(TolReset * TolReset);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgA11:  diag_x_q  <= DiagW'($signed(cfg_data_i[MatW-1:0])) - DiagW'(Q14One);
        CfgA12:  cross_x_q <= $signed(cfg_data_i[MatW-1:0]);
        CfgA21:  cross_y_q <= $signed(cfg_data_i[MatW-1:0]);
        CfgA22:  diag_y_q  <= DiagW'($signed(cfg_data_i[MatW-1:0])) - DiagW'(Q14One);
        CfgOffX: off_x_q   <= $signed(cfg_data_i[OffW-1:0]);
        CfgOffY: off_y_q   <= $signed(cfg_data_i[OffW-1:0]);
        CfgTol:  tol_sq_q  <= TolSqW'(tol_wr) * TolSqW'(tol_wr);
        default: ;
      endcase
    end
  end

  // Stage handshake. A stage takes new data when it is empty or when its
  // content moves on in the same cycle, so bubbles collapse during a stall.
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4        = !v4_q || res_o.ready;
  assign rdy3        = !v3_q || rdy4;
  assign rdy2        = !v2_q || rdy3;
  assign rdy1        = !v1_q || rdy2;
  assign pix_i.ready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= pix_i.valid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // Stage 1: the four matrix products. Coordinates are unsigned, so they are
  // widened with a zero sign bit before the signed multiply.
  logic signed [CoordBits:0] col_s, row_s;
  logic signed [ProdW-1:0]   px_diag_q, px_cross_q, py_diag_q, py_cross_q;
  logic signed [FlowW-1:0]   fx1_q, fy1_q;

  assign col_s = $signed({1'b0, pix_i.pixel_col});
  assign row_s = $signed({1'b0, pix_i.pixel_row});

  always_ff @(posedge clk_i) begin
    if (rdy1 && pix_i.valid) begin
      px_diag_q  <= ProdW'(diag_x_q) * ProdW'(col_s);
      px_cross_q <= ProdW'(cross_x_q) * ProdW'(row_s);
      py_diag_q  <= ProdW'(diag_y_q) * ProdW'(row_s);
      py_cross_q <= ProdW'(cross_y_q) * ProdW'(col_s);
      fx1_q      <= pix_i.flow_x;
      fy1_q      <= pix_i.flow_y;
    end
  end

  // Stage 2: sum the products, round from Q.14 to 1/64 pixel (add half, then
  // floor by an arithmetic shift), add the offset and saturate.
  logic signed [SumW-1:0]   sum_x, sum_y;
  logic signed [PlaneW-1:0] plane_x, plane_y;
  logic signed [FlowW-1:0]  px2_q, py2_q, fx2_q, fy2_q;

  always_comb begin
    sum_x   = SumW'(px_diag_q) + SumW'(px_cross_q) + SumW'(RoundBias);
    sum_y   = SumW'(py_diag_q) + SumW'(py_cross_q) + SumW'(RoundBias);
    plane_x = PlaneW'($signed(sum_x[SumW-1:FracW])) + PlaneW'(off_x_q);
    plane_y = PlaneW'($signed(sum_y[SumW-1:FracW])) + PlaneW'(off_y_q);
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      px2_q <= sat_flow(plane_x);
      py2_q <= sat_flow(plane_y);
      fx2_q <= fx1_q;
      fy2_q <= fy1_q;
    end
  end

  // Stage 3: differences between measured and predicted flow, squared.
  logic signed [DiffW-1:0] dx, dy;
  logic [SqW-1:0]          sq_x_q, sq_y_q;
  logic signed [FlowW-1:0] px3_q, py3_q;

  assign dx = DiffW'(fx2_q) - DiffW'(px2_q);
  assign dy = DiffW'(fy2_q) - DiffW'(py2_q);

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      sq_x_q <= $unsigned(SqW'(dx) * SqW'(dx));
      sq_y_q <= $unsigned(SqW'(dy) * SqW'(dy));
      px3_q  <= px2_q;
      py3_q  <= py2_q;
    end
  end

  // Stage 4: strict compare of the squared distance against the squared
  // tolerance. A zero tolerance can never match.
  logic [DistW-1:0]        dist_sq;
  logic signed [FlowW-1:0] px4_q, py4_q;
  logic [MaskW-1:0]        mask4_q;

  assign dist_sq = DistW'(sq_x_q) + DistW'(sq_y_q);

  always_ff @(posedge clk_i) begin
    if (rdy4 && v3_q) begin
      px4_q   <= px3_q;
      py4_q   <= py3_q;
      mask4_q <= (dist_sq < DistW'(tol_sq_q)) ? MaskOn : MaskOff;
    end
  end

  assign res_o.valid        = v4_q;
  assign res_o.plane_flow_x = px4_q;
  assign res_o.plane_flow_y = py4_q;
  assign res_o.mask_value   = mask4_q;

  // A zero tolerance must always give an empty mask.
  a_zero_tol_no_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && tol_sq_q == '0 |-> res_o.mask_value == MaskOff)
    else $error("mask set with zero tolerance");

  // The mask byte only ever takes its two legal codes.
  a_mask_codes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.mask_value == MaskOn || res_o.mask_value == MaskOff))
    else $error("mask byte is neither on nor off");

  // With every stage full and the output stalled, no pixel may be accepted.
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && v2_q && v3_q && v4_q && !res_o.ready |-> !pix_i.ready)
    else $error("pixel accepted into a full stalled pipeline");

  // An accepted pixel always occupies the first stage in the next cycle.
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_i.valid && pix_i.ready |=> v1_q)
    else $error("accepted pixel lost at stage one");

endmodule

// ===== tb/sv/dominant_plane_flow_mask_tb.sv =====
// Self-checking testbench of the dominant-plane flow mask, with its own plane predictor.
module dominant_plane_flow_mask_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dpfm_pkg::*;

  // Index 7 is not a register. A write to it must leave every register unchanged.
  localparam logic [CfgIdxW-1:0] CfgUnused = 3'd7;

  localparam int ResetRows      = 12;
  localparam int ExtremeRows    = 6;
  localparam int PhaseItems     = 155;
  localparam int DrainCycles    = 8;
  localparam int HoldAtPixels   = 200;
  localparam int HoldCycles     = 300;
  localparam int CycleLimit     = 400000;
  localparam int MaxCoord       = (1 << CoordBits) - 1;

  typedef struct packed {
    logic [CoordBits-1:0]    col;
    logic [CoordBits-1:0]    row;
    logic signed [FlowW-1:0] fx;
    logic signed [FlowW-1:0] fy;
  } pixel_t;

  typedef struct packed {
    logic signed [FlowW-1:0] plane_x;
    logic signed [FlowW-1:0] plane_y;
    logic [MaskW-1:0]        mask;
  } plane_res_t;

  typedef struct packed {
    pixel_t     pix;
    logic       typed;
    plane_res_t want;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0]    cfg_data_i;

  dpfm_pix_if pix ();
  dpfm_res_if res ();

  dominant_plane_flow_mask dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_i      (pix),
    .res_o      (res)
  );

  // The testbench's own copy of the plane model registers, at their reset values.
  logic signed [MatW-1:0] coef_a11 = MatW'(Q14One);
  logic signed [MatW-1:0] coef_a12 = '0;
  logic signed [MatW-1:0] coef_a21 = '0;
  logic signed [MatW-1:0] coef_a22 = MatW'(Q14One);
  logic signed [OffW-1:0] shift_x  = '0;
  logic signed [OffW-1:0] shift_y  = '0;
  logic [TolW-1:0]        tol_q    = TolW'(TolReset);

  plane_res_t flow_expect_q[$];

  int fail_count   = 0;
  int pixels_in    = 0;
  int cycle_count  = 0;
  int tx_idle_pct  = 9;
  int rx_idle_pct  = 48;

  // What the sender offers right now: a typed-in expectation, or none.
  logic       offer_typed = 1'b0;
  plane_res_t offer_want  = '0;

  // Directed rows at reset settings: identity matrix, zero offsets, tolerance 64.
  // The predicted flow is zero, so the mask only depends on fx*fx + fy*fy < 4096.
  dir_row_t reset_rows [ResetRows] = '{
    '{'{12'd0,    12'd0,    16'sd0,      16'sd0},      1'b1, '{16'sd0, 16'sd0, MaskOn}},
    '{'{12'd4095, 12'd4095, 16'sd0,      16'sd0},      1'b1, '{16'sd0, 16'sd0, MaskOn}},
    '{'{12'd0,    12'd0,    16'sd63,     16'sd0},      1'b1, '{16'sd0, 16'sd0, MaskOn}},
    '{'{12'd0,    12'd0,    16'sd64,     16'sd0},      1'b1, '{16'sd0, 16'sd0, MaskOff}},
    '{'{12'd0,    12'd0,    -16'sd63,    16'sd0},      1'b1, '{16'sd0, 16'sd0, MaskOn}},
    '{'{12'd0,    12'd0,    16'sd0,      -16'sd64},    1'b1, '{16'sd0, 16'sd0, MaskOff}},
    '{'{12'd4095, 12'd0,    16'sd32767,  16'sd32767},  1'b1, '{16'sd0, 16'sd0, MaskOff}},
    '{'{12'd0,    12'd4095, -16'sd32768, -16'sd32768}, 1'b1, '{16'sd0, 16'sd0, MaskOff}},
    '{'{12'd2048, 12'd1024, 16'sd45,     16'sd45},     1'b1, '{16'sd0, 16'sd0, MaskOn}},
    '{'{12'd1024, 12'd2048, -16'sd46,    16'sd46},     1'b1, '{16'sd0, 16'sd0, MaskOff}},
    '{'{12'd4095, 12'd4095, 16'sd32767,  -16'sd32768}, 1'b1, '{16'sd0, 16'sd0, MaskOff}},
    '{'{12'd0,    12'd0,    -16'sd32768, 16'sd0},      1'b1, '{16'sd0, 16'sd0, MaskOff}}
  };

  // Pixels sent under the extreme matrix and offset settings; the predictor checks them.
  pixel_t extreme_pix [ExtremeRows] = '{
    '{12'd4095, 12'd4095, 16'sd32767,  16'sd32767},
    '{12'd0,    12'd0,    -16'sd32768, -16'sd32768},
    '{12'd4095, 12'd0,    16'sd0,      16'sd0},
    '{12'd0,    12'd4095, -16'sd1,     16'sd1},
    '{12'd2047, 12'd2048, 16'sd32767,  -16'sd32768},
    '{12'd1,    12'd1,    16'sd0,      -16'sd1}
  };

  function automatic logic signed [FlowW-1:0] clamp_flow(input longint v);
    if (v > FlowMax) return FlowW'(FlowMax);
    if (v < FlowMin) return FlowW'(FlowMin);
    return FlowW'(v);
  endfunction

  // Predicted planar flow (A - I) * p + b and the on-plane mask for one pixel.
  function automatic plane_res_t plane_predict(input pixel_t p);
    longint     acc_x;
    longint     acc_y;
    longint     dx;
    longint     dy;
    longint     dist_sq;
    longint     tol_sq;
    plane_res_t r;
    acc_x = (longint'(coef_a11) - Q14One) * longint'(p.col) + longint'(coef_a12) * longint'(p.row);
    acc_y = (longint'(coef_a22) - Q14One) * longint'(p.row) + longint'(coef_a21) * longint'(p.col);
    // An arithmetic shift of a signed value is the floor of the division by 256.
    r.plane_x = clamp_flow(((acc_x + RoundBias) >>> 8) + longint'(shift_x));
    r.plane_y = clamp_flow(((acc_y + RoundBias) >>> 8) + longint'(shift_y));
    dx = longint'(p.fx) - longint'(r.plane_x);
    dy = longint'(p.fy) - longint'(r.plane_y);
    dist_sq = dx * dx + dy * dy;
    tol_sq = longint'(tol_q) * longint'(tol_q);
    r.mask = (dist_sq < tol_sq) ? MaskOn : MaskOff;
    return r;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Monitor. Everything is sampled at the rising edge, before the block's registers move.
  // Register writes land in the local copy, accepted pixel transactions push their
  // expected result, and accepted result transactions are compared with the oldest one.
  always @(posedge clk_i) begin
    plane_res_t want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgA11:  coef_a11 = cfg_data_i[MatW-1:0];
          CfgA12:  coef_a12 = cfg_data_i[MatW-1:0];
          CfgA21:  coef_a21 = cfg_data_i[MatW-1:0];
          CfgA22:  coef_a22 = cfg_data_i[MatW-1:0];
          CfgOffX: shift_x  = cfg_data_i[OffW-1:0];
          CfgOffY: shift_y  = cfg_data_i[OffW-1:0];
          CfgTol:  tol_q    = cfg_data_i[TolW-1:0];
          default: ;
        endcase
      end
      if (pix.valid && pix.ready) begin
        pixels_in++;
        if (offer_typed) begin
          flow_expect_q.push_back(offer_want);
        end else begin
          flow_expect_q.push_back(plane_predict('{pix.pixel_col, pix.pixel_row,
                                                  pix.flow_x, pix.flow_y}));
        end
      end
      if (res.valid && res.ready) begin
        if (flow_expect_q.size() == 0) begin
          $error("result transaction with no expected result waiting");
          fail_count++;
        end else begin
          want = flow_expect_q.pop_front();
          if (res.plane_flow_x !== want.plane_x) begin
            $error("plane_flow_x: expected %0d, actual %0d",
                   $signed(want.plane_x), $signed(res.plane_flow_x));
            fail_count++;
          end
          if (res.plane_flow_y !== want.plane_y) begin
            $error("plane_flow_y: expected %0d, actual %0d",
                   $signed(want.plane_y), $signed(res.plane_flow_y));
            fail_count++;
          end
          if (res.mask_value !== want.mask) begin
            $error("mask_value: expected %0d, actual %0d", want.mask, res.mask_value);
            fail_count++;
          end
        end
      end
    end
  end

  // Receiver. Ready changes at the falling edge. Once, after enough pixels have gone in,
  // it holds off for a long stretch so that the pipeline fills and stalls its input.
  initial begin
    int  stall_left;
    bit  hold_armed;
    stall_left = 0;
    hold_armed = 1'b1;
    res.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        res.ready <= 1'b0;
      end else if (hold_armed && pixels_in >= HoldAtPixels) begin
        hold_armed = 1'b0;
        stall_left = HoldCycles - 1;
        res.ready <= 1'b0;
      end else begin
        res.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Offer one pixel transaction, with random idle cycles first, and wait for acceptance.
  task automatic offer_pixel(input pixel_t p, input logic typed, input plane_res_t want);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      pix.valid <= 1'b0;
      @(negedge clk_i);
    end
    offer_typed = typed;
    offer_want  = want;
    pix.valid     <= 1'b1;
    pix.pixel_col <= p.col;
    pix.pixel_row <= p.row;
    pix.flow_x    <= p.fx;
    pix.flow_y    <= p.fy;
    @(posedge clk_i);
    while (!pix.ready) @(posedge clk_i);
  endtask

  // Stop offering, then wait until every expected result has come and the pipeline is empty.
  task automatic drain_pipeline();
    @(negedge clk_i);
    pix.valid <= 1'b0;
    while (flow_expect_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Program a random plane. Near-identity planes keep many pixels on the plane; wide ones
  // reach saturation. Bits above a register's width are always random and must be ignored.
  task automatic program_plane(input bit near);
    int a11;
    int a12;
    int a21;
    int a22;
    int offx;
    int offy;
    int tol;
    if (near) begin
      a11  = Q14One + $urandom_range(0, 2048) - 1024;
      a22  = Q14One + $urandom_range(0, 2048) - 1024;
      a12  = $urandom_range(0, 1024) - 512;
      a21  = $urandom_range(0, 1024) - 512;
      offx = $urandom_range(0, 20000) - 10000;
      offy = $urandom_range(0, 20000) - 10000;
      tol  = $urandom_range(0, 800);
    end else begin
      a11  = $urandom;
      a22  = $urandom;
      a12  = $urandom;
      a21  = $urandom;
      offx = $urandom;
      offy = $urandom;
      tol  = $urandom;
    end
    write_reg(CfgA11,  {8'($urandom), 16'(a11)});
    write_reg(CfgA12,  {8'($urandom), 16'(a12)});
    write_reg(CfgA21,  {8'($urandom), 16'(a21)});
    write_reg(CfgA22,  {8'($urandom), 16'(a22)});
    write_reg(CfgOffX, 24'(offx));
    write_reg(CfgOffY, 24'(offy));
    write_reg(CfgTol,  {8'($urandom), 16'(tol)});
    if ($urandom_range(0, 1) == 0) write_reg(CfgUnused, 24'($urandom));
  endtask

  // Random pixels. Half of them carry a flow close to the plane's prediction so that
  // the distance test is exercised around the tolerance; the rest are free.
  task automatic run_random_phase(input int n_items);
    pixel_t     p;
    plane_res_t guess;
    int         spread;
    for (int i = 0; i < n_items; i++) begin
      p.col = CoordBits'($urandom);
      p.row = CoordBits'($urandom);
      if ($urandom_range(0, 7) == 0) p.col = ($urandom_range(0, 1) == 0) ? '0 : CoordBits'(MaxCoord);
      if ($urandom_range(0, 7) == 0) p.row = ($urandom_range(0, 1) == 0) ? '0 : CoordBits'(MaxCoord);
      p.fx = FlowW'($urandom);
      p.fy = FlowW'($urandom);
      if ($urandom_range(0, 1) == 0) begin
        guess  = plane_predict(p);
        spread = int'(tol_q) + 4;
        p.fx = clamp_flow(longint'(guess.plane_x) + $urandom_range(0, 2 * spread) - spread);
        p.fy = clamp_flow(longint'(guess.plane_y) + $urandom_range(0, 2 * spread) - spread);
      end
      offer_pixel(p, 1'b0, '0);
    end
  endtask

  // Main sequence: reset, directed rows, extreme settings, then random phases under
  // three idle profiles. Registers are only written once the pipeline has drained.
  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    pix.valid     = 1'b0;
    pix.pixel_col = '0;
    pix.pixel_row = '0;
    pix.flow_x    = '0;
    pix.flow_y    = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < ResetRows; i++) begin
      offer_pixel(reset_rows[i].pix, reset_rows[i].typed, reset_rows[i].want);
    end
    drain_pipeline();

    // Largest matrix entries and offsets with the widest tolerance, then the opposite
    // extremes with a zero tolerance, which must never report a pixel on the plane.
    write_reg(CfgA11,  24'(FlowMax));
    write_reg(CfgA12,  24'(FlowMax));
    write_reg(CfgA21,  24'(FlowMin));
    write_reg(CfgA22,  24'(FlowMin));
    write_reg(CfgOffX, 24'h7FFFFF);
    write_reg(CfgOffY, 24'h800000);
    write_reg(CfgTol,  24'h00FFFF);
    for (int i = 0; i < ExtremeRows; i++) offer_pixel(extreme_pix[i], 1'b0, '0);
    drain_pipeline();

    write_reg(CfgA11,  24'(FlowMin));
    write_reg(CfgA12,  24'(FlowMin));
    write_reg(CfgA21,  24'(FlowMax));
    write_reg(CfgA22,  24'(FlowMax));
    write_reg(CfgOffX, 24'h800000);
    write_reg(CfgOffY, 24'h7FFFFF);
    write_reg(CfgTol,  24'hFF0000);
    write_reg(CfgUnused, 24'hFFFFFF);
    for (int i = 0; i < ExtremeRows; i++) offer_pixel(extreme_pix[i], 1'b0, '0);
    drain_pipeline();

    for (int prof = 0; prof < 3; prof++) begin
      case (prof)
        0: begin
          tx_idle_pct = 9;
          rx_idle_pct = 48;
        end
        1: begin
          tx_idle_pct = 48;
          rx_idle_pct = 9;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (int ph = 0; ph < 4; ph++) begin
        program_plane(ph % 2 == 0);
        run_random_phase(PhaseItems);
        drain_pipeline();
      end
    end

    if (fail_count == 0 && flow_expect_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
